// File: hdl/assert_macros.svh
// Assertion helpers, clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define SKPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define SKPI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hdl/skpi_pkg.sv
package skpi_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] key;
    logic [30:0] record_position;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [30:0] found_position;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [30:0] key;
    logic [30:0] pos;
  } entry_t;

endpackage

// File: hdl/skpi_mem.sv
module skpi_mem #(
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  skpi_pkg::entry_t         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output skpi_pkg::entry_t         rdata_o
);

  skpi_pkg::entry_t mem_q [Depth];
  skpi_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sorted_key_position_index.sv
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+-------------------------
// in      | input     | in_valid_i / in_stall_o  | in_data_i  (skpi_pkg::req_t)
// out     | output    | out_valid_o / out_stall_i| out_data_o (skpi_pkg::rsp_t)
//
// One request at a time; the table walk reads one memory entry per cycle.
// Insert walks down from the last entry; a full table gets no walk.
// Lookup and remove walk up from entry 0; lookup stops on a hit.
// Reset clears the entry count, state and output valid; memory contents need no clearing pass.
// A new request is taken while the previous result waits on out_stall_i.
`include "assert_macros.svh"

module sorted_key_position_index #(
  parameter int CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  skpi_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output skpi_pkg::rsp_t  out_data_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_PUT  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    j_q, j_d;
  logic [AW-1:0]    put_q, put_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             found_q, found_d;
  skpi_pkg::req_t   req_q, req_d;
  skpi_pkg::rsp_t   res_q, res_d;
  skpi_pkg::rsp_t   out_q;
  logic             out_valid_q;

  logic             we;
  logic [AW-1:0]    wr_addr;
  skpi_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr;
  skpi_pkg::entry_t rd_data;

  logic [CW-1:0]    cnt_m1;
  logic             last;
  logic             shift;
  logic             out_load;

  skpi_mem #(
    .Depth(CAPACITY)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  assign cnt_m1   = cnt_q - CW'(1);
  assign last     = (CW'(j_q) == cnt_m1);
  assign shift    = (j_q != '0) ? (rd_data.key >= req_q.key) : (rd_data.key > req_q.key);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    put_d   = put_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    req_d   = req_q;
    res_d   = res_q;
    we      = 1'b0;
    wr_addr = put_q;
    wr_data = '{key: req_q.key, pos: req_q.record_position};
    rd_addr = j_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d                = in_data_i;
          found_d              = 1'b0;
          res_d.status         = skpi_pkg::STAT_OK;
          res_d.found_position = '0;
          res_d.entry_count    = '0;
          unique case (in_data_i.kind) inside
            skpi_pkg::KIND_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_d.status = skpi_pkg::STAT_FULL;
                state_d      = ST_DONE;
              end else if (cnt_q == '0) begin
                put_d   = '0;
                state_d = ST_PUT;
              end else begin
                j_d     = cnt_m1[AW-1:0];
                rd_addr = cnt_m1[AW-1:0];
                state_d = ST_INS;
              end
            end
            skpi_pkg::KIND_LOOKUP, skpi_pkg::KIND_REMOVE: begin
              if (cnt_q == '0) begin
                res_d.status = skpi_pkg::STAT_MISS;
                state_d      = ST_DONE;
              end else begin
                j_d     = '0;
                rd_addr = '0;
                state_d = ST_SCAN;
              end
            end
            skpi_pkg::KIND_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_INS: begin
        rd_addr = j_q - AW'(1);
        if (shift) begin
          we      = 1'b1;
          wr_addr = j_q + AW'(1);
          wr_data = rd_data;
          if (j_q == '0) begin
            put_d   = '0;
            state_d = ST_PUT;
          end else begin
            j_d = j_q - AW'(1);
          end
        end else begin
          put_d   = j_q + AW'(1);
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        we      = 1'b1;
        cnt_d   = cnt_q + CW'(1);
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        rd_addr = j_q + AW'(1);
        j_d     = j_q + AW'(1);
        if (!found_q) begin
          if (rd_data.key == req_q.key) begin
            if (req_q.kind == skpi_pkg::KIND_LOOKUP) begin
              res_d.found_position = rd_data.pos;
              state_d              = ST_DONE;
            end else begin
              found_d = 1'b1;
              if (last) begin
                cnt_d   = cnt_m1;
                state_d = ST_DONE;
              end
            end
          end else if (last) begin
            res_d.status = skpi_pkg::STAT_MISS;
            state_d      = ST_DONE;
          end
        end else begin
          we      = 1'b1;
          wr_addr = j_q - AW'(1);
          wr_data = rd_data;
          if (last) begin
            cnt_d   = cnt_m1;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    put_q <= put_d;
    req_q <= req_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= '{status:         res_q.status,
                 found_position: res_q.found_position,
                 entry_count:    5'(cnt_q)};
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SKPI_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "entry count above capacity")
  `SKPI_ASSERT(a_walk_in_range, (state_q == ST_INS || state_q == ST_SCAN) |-> (CW'(j_q) < cnt_q), "walk index past entry count")
  `SKPI_ASSERT(a_put_room, (state_q == ST_PUT) |-> (cnt_q < CW'(CAPACITY) && CW'(put_q) <= cnt_q), "insert write without room")

endmodule

// File: tb/skpi_index_checker.sv
module skpi_index_checker #(
  parameter int CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  skpi_pkg::req_t   in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  skpi_pkg::rsp_t   out_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output int               lookup_hits_o,
  output int               remove_hits_o,
  output int               full_refusals_o,
  output int               peak_fill_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import skpi_pkg::*;

  logic [30:0] shadow_key [CAPACITY];
  logic [30:0] shadow_pos [CAPACITY];
  int          shadow_fill;
  rsp_t        awaited_rsp [$];

  int fails;
  int checked;
  int lookup_hits;
  int remove_hits;
  int full_refusals;
  int peak_fill;

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t ns: result %0d: %s", $time, checked, what);
  endtask

  task automatic predict_index_request(input req_t rq, output rsp_t want);
    int slot;
    int j;
    want.status = STAT_OK;
    want.found_position = '0;
    slot = 0;
    case (rq.kind)
      KIND_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          want.status = STAT_FULL;
          full_refusals++;
        end else begin
          // an equal first key keeps its place; the scan starts behind it
          if (shadow_fill != 0 && shadow_key[0] <= rq.key) begin
            slot = 1;
            while (slot < shadow_fill && shadow_key[slot] < rq.key) slot++;
          end
          for (j = shadow_fill; j > slot; j--) begin
            shadow_key[j] = shadow_key[j - 1];
            shadow_pos[j] = shadow_pos[j - 1];
          end
          shadow_key[slot] = rq.key;
          shadow_pos[slot] = rq.record_position;
          shadow_fill++;
        end
      end
      KIND_LOOKUP, KIND_REMOVE: begin
        while (slot < shadow_fill && shadow_key[slot] != rq.key) slot++;
        if (slot == shadow_fill) begin
          want.status = STAT_MISS;
        end else if (rq.kind == KIND_LOOKUP) begin
          want.found_position = shadow_pos[slot];
          lookup_hits++;
        end else begin
          for (j = slot; j + 1 < shadow_fill; j++) begin
            shadow_key[j] = shadow_key[j + 1];
            shadow_pos[j] = shadow_pos[j + 1];
          end
          shadow_fill--;
          remove_hits++;
        end
      end
      default: begin
        shadow_fill = 0;
      end
    endcase
    want.entry_count = 5'(shadow_fill);
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      shadow_fill = 0;
      awaited_rsp.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer: status %0d pos %0h count %0d",
                                    got.status, got.found_position, got.entry_count));
        end else begin
          want = awaited_rsp.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.found_position !== want.found_position)
            report_mismatch($sformatf("found_position %0h, expected %0h",
                                      got.found_position, want.found_position));
          if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      got.entry_count, want.entry_count));
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_index_request(in_data_i, want);
        awaited_rsp.push_back(want);
      end
    end
    fail_count_o    <= fails;
    pending_o       <= awaited_rsp.size();
    checked_o       <= checked;
    lookup_hits_o   <= lookup_hits;
    remove_hits_o   <= remove_hits;
    full_refusals_o <= full_refusals;
    peak_fill_o     <= peak_fill;
  end

endmodule

// File: tb/tb_sorted_key_position_index.sv
module tb_sorted_key_position_index;
  timeunit 1ns;
  timeprecision 1ps;
  import skpi_pkg::*;

  localparam int          CAPACITY     = 16;
  localparam int          RANDOM_ITEMS = 1420;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          POOL_SIZE    = 8;
  localparam logic [30:0] KEY_MAX      = 31'h7FFF_FFFF;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  int fail_count;
  int pending;
  int checked;
  int lookup_hits;
  int remove_hits;
  int full_refusals;
  int peak_fill;
  int cycles = 0;

  bit          send_quiet = 1'b0;
  logic [30:0] key_pool [POOL_SIZE];

  sorted_key_position_index #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  skpi_index_checker #(
    .CAPACITY(CAPACITY)
  ) index_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .lookup_hits_o  (lookup_hits),
    .remove_hits_o  (remove_hits),
    .full_refusals_o(full_refusals),
    .peak_fill_o    (peak_fill)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic req_t pack_request(kind_e kind, logic [30:0] key, logic [30:0] pos);
    req_t rq;
    rq.kind = kind;
    rq.key = key;
    rq.record_position = pos;
    return rq;
  endfunction

  // mostly small keys so duplicates and hits are common
  function automatic logic [30:0] pool_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 31'($urandom_range(0, 40));
    if (roll < 8) return 31'($urandom());
    if (roll == 8) return KEY_MAX;
    return 31'd0;
  endfunction

  function automatic req_t random_request(int insert_pct);
    req_t rq;
    int   roll;
    rq.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    rq.record_position = 31'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 2) rq.kind = KIND_CLEAR;
    else if (roll < 2 + insert_pct) rq.kind = KIND_INSERT;
    else if (roll < 2 + insert_pct + (98 - insert_pct) / 2) rq.kind = KIND_LOOKUP;
    else rq.kind = KIND_REMOVE;
    if ($urandom_range(0, 9) == 0) rq.key = 31'($urandom());
    return rq;
  endfunction

  task automatic send_request(input req_t rq);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin : receiver
    int gap;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    forever begin
      // long hold-off: the block backs up and stalls its input
      if (taken == 60 || taken == 800) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    int n;
    int left;
    int burst;
    int insert_pct;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = pool_key();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(pack_request(KIND_LOOKUP, 31'd0, KEY_MAX));
    send_request(pack_request(KIND_REMOVE, KEY_MAX, 31'd0));
    send_request(pack_request(KIND_CLEAR, KEY_MAX, KEY_MAX));
    send_request(pack_request(KIND_INSERT, KEY_MAX, KEY_MAX));
    send_request(pack_request(KIND_INSERT, 31'd0, 31'd0));
    send_request(pack_request(KIND_INSERT, 31'd0, 31'd1));
    send_request(pack_request(KIND_LOOKUP, 31'd0, 31'd5));
    send_request(pack_request(KIND_REMOVE, 31'd0, 31'd0));
    send_request(pack_request(KIND_LOOKUP, KEY_MAX, 31'd0));
    for (n = 0; n < CAPACITY - 2; n++)
      send_request(pack_request(KIND_INSERT, 31'(500 - 37 * n), 31'($urandom())));
    send_request(pack_request(KIND_INSERT, 31'd7, 31'd7));
    send_request(pack_request(KIND_LOOKUP, 31'd1, 31'd0));
    send_request(pack_request(KIND_CLEAR, 31'd0, 31'd0));

    // each session randomly favours either filling or draining the table
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(40, 160);
      insert_pct = ($urandom_range(0, 1) == 1) ? 65 : 30;
      send_quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < burst && left > 0; n++) begin
        if ($urandom_range(0, 15) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = pool_key();
        send_request(random_request(insert_pct));
        left--;
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: %0d lookup hits, %0d removes that found their key",
             checked, lookup_hits, remove_hits);
    $display("%0d inserts turned away on a full table, peak fill %0d of %0d entries",
             full_refusals, peak_fill, CAPACITY);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
